// ----- src/sum_checked_packet_deframer_core_assert.svh -----
// Assertion macros for the packet deframer.
// Used by the top level only; expects clk and rst in scope.
`ifndef SUM_CHECKED_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define SUM_CHECKED_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset
`define SCPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset
`define SCPD_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- src/scpd_pkg.sv -----
// Shared types and constants for the packet deframer.
// No dependencies; used by all modules.
`timescale 1ns / 1ps

package scpd_pkg;

  localparam logic [7:0] HEADER_VALUE = 8'hFF;

  // Result kind codes
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // One result beat
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] packet_id;
    logic [7:0] command;
    logic [7:0] length;
    logic       checksum_ok;
  } result_t;

  // Occupancy of the output queue
  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } skid_status_t;

endpackage

// ----- src/scpd_in_if.sv -----
// Input channel: one received byte per beat.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface scpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- src/scpd_out_if.sv -----
// Output channel: payload bytes and end-of-packet verdicts.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface scpd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] packet_id;
  logic [7:0] command;
  logic [7:0] length;
  logic       checksum_ok;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output packet_id, output command, output length, output checksum_ok,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_index,
                  input packet_id, input command, input length, input checksum_ok,
                  output ready);
endinterface

// ----- src/scpd_parser.sv -----
// Frame parser: header hunt, field capture, running sum and check.
// Depends on scpd_pkg.
`timescale 1ns / 1ps

module scpd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            beat,
  input  logic [7:0]      rx_byte,
  output logic            push,
  output scpd_pkg::result_t push_data,
  output logic            hunting
);
  import scpd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ID   = 3'd1,
    PH_CMD  = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CK1  = 3'd5,
    PH_CK2  = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  held_id, held_command, held_length;
  logic [7:0]  payload_count, count_inc;
  logic [15:0] running_sum, sum_add;
  logic [7:0]  first_check_byte;

  assign count_inc = payload_count + 8'd1;
  assign sum_add   = running_sum + {8'd0, rx_byte};
  assign hunting   = (phase == PH_HUNT);

  // Next phase and result for the current beat
  always_comb begin
    phase_next = phase;
    push       = 1'b0;
    push_data  = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, payload_index: 8'd0,
                   packet_id: held_id, command: held_command, length: held_length,
                   checksum_ok: 1'b0};
    unique case (phase)
      PH_ID:   phase_next = PH_CMD;
      PH_CMD:  phase_next = PH_LEN;
      PH_LEN:  phase_next = (rx_byte == 8'd0) ? PH_CK1 : PH_DATA;
      PH_DATA: begin
        push                    = beat;
        push_data.payload_byte  = rx_byte;
        push_data.payload_index = payload_count;
        if (count_inc == held_length) phase_next = PH_CK1;
      end
      PH_CK1:  phase_next = PH_CK2;
      PH_CK2:  begin
        push                  = beat;
        push_data.kind        = KIND_END;
        push_data.checksum_ok = (first_check_byte == running_sum[15:8]) &&
                                (rx_byte == running_sum[7:0]);
        phase_next            = PH_HUNT;
      end
      default: phase_next = (rx_byte == HEADER_VALUE) ? PH_ID : PH_HUNT;
    endcase
  end

  // Phase and held fields
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      held_id          <= 8'd0;
      held_command     <= 8'd0;
      held_length      <= 8'd0;
      payload_count    <= 8'd0;
      running_sum      <= 16'd0;
      first_check_byte <= 8'd0;
    end else if (beat) begin
      phase <= phase_next;
      unique case (phase)
        PH_ID: begin
          held_id     <= rx_byte;
          running_sum <= sum_add;
        end
        PH_CMD: begin
          held_command <= rx_byte;
          running_sum  <= sum_add;
        end
        PH_LEN: begin
          held_length   <= rx_byte;
          running_sum   <= sum_add;
          payload_count <= 8'd0;
        end
        PH_DATA: begin
          running_sum   <= sum_add;
          payload_count <= count_inc;
        end
        PH_CK1: first_check_byte <= rx_byte;
        PH_CK2: ;
        default: begin
          if (rx_byte == HEADER_VALUE) begin
            running_sum   <= {8'd0, HEADER_VALUE};
            payload_count <= 8'd0;
          end
        end
      endcase
    end
  end

endmodule

// ----- src/scpd_skid.sv -----
// Two-entry output queue: output register plus skid register.
// Depends on scpd_pkg.
`timescale 1ns / 1ps

module scpd_skid (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  scpd_pkg::result_t      push_data,
  input  logic                   pop_ready,
  output logic                   out_valid,
  output scpd_pkg::result_t      out_data,
  output scpd_pkg::skid_status_t status
);
  import scpd_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    advance;

  // Output register free this cycle
  assign advance = !out_valid || pop_ready;
  assign status  = '{out_valid: out_valid, skid_valid: skid_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (advance) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= push;
        skid_data  <= push_data;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule

// ----- src/sum_checked_packet_deframer_core.sv -----
// Packet deframer top level: parser feeding a two-entry output queue.
// Depends on scpd_pkg, scpd_in_if, scpd_out_if, scpd_parser, scpd_skid.
//
//   port  dir   beat carries
//   rx    in    rx_byte, one received byte
//   res   out   kind, payload_byte, payload_index, packet_id, command, length, checksum_ok
//
// One byte per cycle while rx.ready is high; results are registered in the queue.
// The parser state advances on every accepted byte with a sum add and a count compare.
// rx.ready drops only while both output entries are full.
// Reset (synchronous) returns the parser to header hunt and empties the queue.
`timescale 1ns / 1ps
`include "sum_checked_packet_deframer_core_assert.svh"

module sum_checked_packet_deframer_core (
  input  logic      clk,
  input  logic      rst,
  scpd_in_if.sink   rx,
  scpd_out_if.source res
);
  import scpd_pkg::*;

  logic         beat;
  logic         push;
  result_t      push_data;
  result_t      res_data;
  logic         hunting;
  skid_status_t skid_st;

  assign rx.ready = !skid_st.skid_valid;
  assign beat     = rx.valid && rx.ready;

  scpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .rx_byte   (rx.rx_byte),
    .push      (push),
    .push_data (push_data),
    .hunting   (hunting)
  );

  scpd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop_ready (res.ready),
    .out_valid (res.valid),
    .out_data  (res_data),
    .status    (skid_st)
  );

  // Output fields
  assign res.kind          = res_data.kind;
  assign res.payload_byte  = res_data.payload_byte;
  assign res.payload_index = res_data.payload_index;
  assign res.packet_id     = res_data.packet_id;
  assign res.command       = res_data.command;
  assign res.length        = res_data.length;
  assign res.checksum_ok   = res_data.checksum_ok;

  // Checks
  `SCPD_ASSERT(a_skid_behind_out, skid_st.skid_valid |-> skid_st.out_valid, "skid without output")
  `SCPD_ASSERT(a_hunt_silent, (beat && hunting) |-> !push, "result while hunting")
  `SCPD_ASSERT(a_end_rehunts, (push && push_data.kind == KIND_END) |=> hunting, "no rehunt")
  `SCPD_NEVER(a_push_only_on_beat, push && !beat, "result pushed without a byte")

endmodule

// ----- test/scpd_deframe_checker.sv -----
// Checker for the packet deframer: tracks framing on the byte channel and
// compares every result beat. Depends on scpd_pkg, scpd_in_if, scpd_out_if.
`timescale 1ns / 1ps

module scpd_deframe_checker (
  input  logic        clk,
  input  logic        rst,
  scpd_in_if          rx,
  scpd_out_if         res,
  output int unsigned fail_count,
  output int unsigned pending
);
  import scpd_pkg::*;

  typedef enum logic [2:0] {
    HUNT, TAKE_ID, TAKE_CMD, TAKE_LEN, TAKE_DATA, TAKE_CK_HI, TAKE_CK_LO
  } frame_phase_e;

  frame_phase_e frame_phase;
  logic [7:0]   id_q, cmd_q, len_q, count_q, ck_hi_q;
  logic [15:0]  sum_q;
  result_t      expected_results[$];

  // Advance the framing state by one byte, queueing any result it causes
  task automatic deframe_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (frame_phase)
      TAKE_ID: begin
        id_q        = b;
        sum_q       = sum_q + 16'(b);
        frame_phase = TAKE_CMD;
      end
      TAKE_CMD: begin
        cmd_q       = b;
        sum_q       = sum_q + 16'(b);
        frame_phase = TAKE_LEN;
      end
      TAKE_LEN: begin
        len_q       = b;
        sum_q       = sum_q + 16'(b);
        count_q     = '0;
        frame_phase = (b == 8'd0) ? TAKE_CK_HI : TAKE_DATA;
      end
      TAKE_DATA: begin
        sum_q           = sum_q + 16'(b);
        r.kind          = KIND_PAYLOAD;
        r.payload_byte  = b;
        r.payload_index = count_q;
        r.packet_id     = id_q;
        r.command       = cmd_q;
        r.length        = len_q;
        expected_results.push_back(r);
        count_q = count_q + 8'd1;
        if (count_q == len_q) frame_phase = TAKE_CK_HI;
      end
      TAKE_CK_HI: begin
        ck_hi_q     = b;
        frame_phase = TAKE_CK_LO;
      end
      TAKE_CK_LO: begin
        r.kind        = KIND_END;
        r.packet_id   = id_q;
        r.command     = cmd_q;
        r.length      = len_q;
        r.checksum_ok = (ck_hi_q == sum_q[15:8]) && (b == sum_q[7:0]);
        expected_results.push_back(r);
        frame_phase = HUNT;
      end
      default: begin
        // anything but the header is dropped while hunting
        if (b == HEADER_VALUE) begin
          sum_q       = 16'(HEADER_VALUE);
          count_q     = '0;
          frame_phase = TAKE_ID;
        end else begin
          frame_phase = HUNT;
        end
      end
    endcase
  endtask

  function automatic string fmt_result(input result_t r);
    return $sformatf("kind=%0d byte=%02h idx=%0d id=%02h cmd=%02h len=%0d ok=%0d",
                     r.kind, r.payload_byte, r.payload_index, r.packet_id, r.command,
                     r.length, r.checksum_ok);
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      frame_phase = HUNT;
      id_q        = '0;
      cmd_q       = '0;
      len_q       = '0;
      count_q     = '0;
      ck_hi_q     = '0;
      sum_q       = '0;
      expected_results.delete();
      fail_count  = 0;
    end else begin
      // predict first so a beat and its result can share an edge
      if (rx.valid && rx.ready) deframe_byte(rx.rx_byte);

      if (res.valid && res.ready) begin
        got.kind          = res.kind;
        got.payload_byte  = res.payload_byte;
        got.payload_index = res.payload_index;
        got.packet_id     = res.packet_id;
        got.command       = res.command;
        got.length        = res.length;
        got.checksum_ok   = res.checksum_ok;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("%0t: unexpected result %s", $realtime, fmt_result(got));
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
              got.payload_index !== want.payload_index || got.packet_id !== want.packet_id ||
              got.command !== want.command || got.length !== want.length ||
              got.checksum_ok !== want.checksum_ok) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch", $realtime);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- test/sum_checked_packet_deframer_core_test.sv -----
// Testbench top for the packet deframer: drives framed byte streams with
// noise, bad checksums and broken packets. Depends on scpd_pkg, the channel
// interfaces, the deframer core and scpd_deframe_checker.
`timescale 1ns / 1ps

module sum_checked_packet_deframer_core_test;
  import scpd_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PACKET_BYTES = 1350;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending;
  int          burst_left   = 0;
  int          ready_left   = 0;
  int          idle_cycles  = 0;
  int          packet_bytes = 0;
  bit          steady_sender = 1'b0;

  scpd_in_if  rx_ch ();
  scpd_out_if res_ch ();

  sum_checked_packet_deframer_core u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  scpd_deframe_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: long open stretches mixed with short on/off runs
  always @(posedge clk) begin
    int pick;
    if (rst) begin
      res_ch.ready <= 1'b0;
      ready_left = 0;
    end else if (ready_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        res_ch.ready <= 1'b1;
        ready_left = $urandom_range(40, 150);
      end else if (pick < 7) begin
        res_ch.ready <= 1'b1;
        ready_left = $urandom_range(1, 8);
      end else begin
        res_ch.ready <= 1'b0;
        ready_left = $urandom_range(1, 6);
      end
    end else begin
      ready_left--;
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One beat on the byte channel; bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    bit taken;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do begin
      @(negedge clk);
      taken = rx_ch.ready;
      @(posedge clk);
    end while (!taken);
    burst_left--;
  endtask

  // Hold the sender off until every outstanding result has come out
  task automatic wait_for_results();
    rx_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    burst_left = 0;
  endtask

  // Bytes that the deframer drops while hunting
  task automatic send_noise(input int count);
    int i;
    for (i = 0; i < count; i++) send_byte(8'($urandom_range(0, 254)));
  endtask

  // Full packet; ck_fault flips the high/low check byte, truncate stops early
  task automatic send_packet(input logic [7:0] id, input logic [7:0] cmd,
                             input logic [7:0] len, input bit use_fill,
                             input logic [7:0] fill, input logic [1:0] ck_fault,
                             input bit truncate);
    logic [15:0] sum;
    logic [7:0]  b;
    int          n;
    int          i;
    sum = 16'(HEADER_VALUE);
    sum = sum + 16'(id) + 16'(cmd) + 16'(len);
    send_byte(HEADER_VALUE);
    send_byte(id);
    send_byte(cmd);
    send_byte(len);
    n = truncate ? $urandom_range(0, len) : len;
    for (i = 0; i < n; i++) begin
      b   = use_fill ? fill : 8'($urandom);
      sum = sum + 16'(b);
      send_byte(b);
    end
    packet_bytes += 4 + n;
    if (!truncate) begin
      send_byte(sum[15:8] ^ (ck_fault[1] ? 8'($urandom_range(1, 255)) : 8'h00));
      send_byte(sum[7:0] ^ (ck_fault[0] ? 8'($urandom_range(1, 255)) : 8'h00));
      packet_bytes += 2;
    end
  endtask

  initial begin
    int         pick;
    logic [7:0] len;
    logic [1:0] fault;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: hunting drops, zero length, header value as data, bad checks
    send_byte(8'h00);
    send_byte(8'hFE);
    send_packet(8'h00, 8'h00, 8'd0, 1'b0, 8'h00, 2'b00, 1'b0);
    send_packet(8'hFF, 8'hFF, 8'd2, 1'b1, 8'hFF, 2'b00, 1'b0);
    send_packet(8'h5A, 8'hA5, 8'd1, 1'b0, 8'h00, 2'b10, 1'b0);
    wait_for_results();

    // Longest packet of all-ones payload: the sum wraps
    send_packet(8'($urandom), 8'($urandom), 8'd255, 1'b1, 8'hFF, 2'b00, 1'b0);

    // Random packets, mostly well formed and short
    while (packet_bytes < PACKET_BYTES) begin
      if ($urandom_range(0, 5) == 0) steady_sender = !steady_sender;
      pick = $urandom_range(0, 99);
      if (pick < 5)       len = 8'd0;
      else if (pick < 88) len = 8'($urandom_range(1, 12));
      else if (pick < 97) len = 8'($urandom_range(13, 64));
      else                len = 8'($urandom_range(200, 255));
      fault = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
      send_packet(8'($urandom), 8'($urandom), len, $urandom_range(0, 15) == 0,
                  8'($urandom), fault, $urandom_range(0, 29) == 0);
      if ($urandom_range(0, 7) == 0) send_noise($urandom_range(1, 4));
      if ($urandom_range(0, 24) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/scpd_pkg.sv
src/scpd_in_if.sv
src/scpd_out_if.sv
src/scpd_parser.sv
src/scpd_skid.sv
src/sum_checked_packet_deframer_core.sv
test/scpd_deframe_checker.sv
test/sum_checked_packet_deframer_core_test.sv
